>>> rtl/core/pcm_pkg.sv
package pcm_pkg;

    localparam int SAMPLE_DEPTH_DEF = 16384;
    localparam int FRACTION_BITS    = 10;
    localparam int MAX_ADDR_W       = 20;

    localparam int CMD_W    = 2;
    localparam int SADDR_W  = 14;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int POS_W    = 32;
    localparam int STEP_W   = 20;
    localparam int COUNT_W  = 15;
    localparam int VOL_W    = 16;
    localparam int PAN_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PROD_W   = SAMPLE_W + VOL_W + 1;
    localparam int GAIN_SHIFT = 12;
    localparam int VAL_W    = PROD_W - GAIN_SHIFT;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KEYON = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MUTE   = 3'd4;

    localparam logic [STEP_W-1:0]  STEP_RESET   = 20'd1024;
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 15'd0;
    localparam logic [VOL_W-1:0]   VOLUME_RESET = 16'd4096;
    localparam logic [PAN_W-1:0]   PAN_RESET    = 2'd3;

    typedef struct packed {
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] sample_count;
        logic [VOL_W-1:0]   volume;
        logic [PAN_W-1:0]   pan;
        logic               mute;
    } cfg_t;

    // One classified transaction on its way from the front to the back.
    typedef struct packed {
        logic                       we;
        logic                       rd_ok;
        logic                       playing;
        logic [MAX_ADDR_W-1:0]      addr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic signed [ACC_W-1:0]    left;
        logic signed [ACC_W-1:0]    right;
    } entry_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {{(ACC_W + 1 - VAL_W){b[VAL_W-1]}}, b};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/pcm_front.sv
module pcm_front #(
    parameter int SAMPLE_DEPTH = pcm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pcm_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    input  logic                                 q_full,
    input  logic [pcm_pkg::CMD_W-1:0]            command,
    input  logic [pcm_pkg::SADDR_W-1:0]          sample_addr,
    input  logic signed [pcm_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic signed [pcm_pkg::ACC_W-1:0]     left_in,
    input  logic signed [pcm_pkg::ACC_W-1:0]     right_in,
    output logic                                 push,
    output pcm_pkg::entry_t                      entry
);
    import pcm_pkg::*;

    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] idx_ext;
    logic [POS_W-1:0] waddr_ext;
    logic             play;

    assign push      = in_valid && !q_full;
    assign end_pos   = POS_W'(cfg.sample_count) << FRACTION_BITS;
    assign idx_ext   = position_reg >> FRACTION_BITS;
    assign waddr_ext = POS_W'(sample_addr);
    assign play      = (command == CMD_TICK) && (position_reg < end_pos);

    always_comb
    begin
        entry.we      = (command == CMD_WRITE) && (waddr_ext < POS_W'(SAMPLE_DEPTH));
        entry.rd_ok   = play && (idx_ext < POS_W'(SAMPLE_DEPTH));
        entry.playing = play;
        entry.addr    = (command == CMD_WRITE) ? waddr_ext[MAX_ADDR_W-1:0]
                                               : idx_ext[MAX_ADDR_W-1:0];
        entry.wdata   = sample_value;
        entry.left    = left_in;
        entry.right   = right_in;
    end

    always_comb
    begin
        position_next = position_reg;
        if (push)
        begin
            if (command == CMD_KEYON)
            begin
                position_next = '0;
            end
            else if (play)
            begin
                position_next = position_reg + POS_W'(cfg.step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '1;
        end
        else
        begin
            position_reg <= position_next;
        end
    end

endmodule

>>> rtl/core/pcm_queue.sv
module pcm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcm_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            q_valid,
    output pcm_pkg::entry_t q_entry
);
    import pcm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    entry_t         slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/pcm_back.sv
module pcm_back #(
    parameter int SAMPLE_DEPTH = pcm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pcm_pkg::cfg_t                     cfg,
    input  logic                              q_valid,
    input  pcm_pkg::entry_t                   q_entry,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [pcm_pkg::ACC_W-1:0]  left_out,
    output logic signed [pcm_pkg::ACC_W-1:0]  right_out,
    output logic                              playing
);
    import pcm_pkg::*;

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

    logic signed [SAMPLE_W-1:0] store_mem [SAMPLE_DEPTH];

    logic                       adv;
    logic                       s1_valid_reg;
    logic                       s1_rd_ok_reg;
    logic                       s1_playing_reg;
    logic signed [ACC_W-1:0]    s1_left_reg;
    logic signed [ACC_W-1:0]    s1_right_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic                       s2_valid_reg;
    logic                       s2_playing_reg;
    logic signed [ACC_W-1:0]    s2_left_reg;
    logic signed [ACC_W-1:0]    s2_right_reg;
    logic signed [PROD_W-1:0]   product_reg;
    logic signed [PROD_W-1:0]   product_next;
    logic signed [SAMPLE_W-1:0] sample_sel;

    logic                       s3_valid_reg;
    logic                       s3_playing_reg;
    logic signed [ACC_W-1:0]    s3_left_reg;
    logic signed [ACC_W-1:0]    s3_right_reg;
    logic signed [ACC_W-1:0]    left_next;
    logic signed [ACC_W-1:0]    right_next;
    logic signed [VAL_W-1:0]    val;

    // The whole pipe moves together unless a finished transaction is held up.
    assign adv = !(s3_valid_reg && out_stall);
    assign pop = q_valid && adv;

    // The store sees writes and reads in transaction order, so a tick
    // always reads what earlier writes left behind.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (q_entry.we)
            begin
                store_mem[q_entry.addr[AW-1:0]] <= q_entry.wdata;
            end
            rd_data_reg <= store_mem[q_entry.addr[AW-1:0]];
        end
    end

    assign sample_sel   = s1_rd_ok_reg ? rd_data_reg : '0;
    assign product_next = PROD_W'(sample_sel) * PROD_W'($signed({1'b0, cfg.volume}));

    // Taking the top bits of the product is a floor shift by twelve.
    assign val = product_reg[PROD_W-1:GAIN_SHIFT];

    always_comb
    begin
        left_next  = s2_left_reg;
        right_next = s2_right_reg;
        if (s2_playing_reg && !cfg.mute)
        begin
            if (cfg.pan[1])
            begin
                left_next = sat_add(s2_left_reg, val);
            end
            if (cfg.pan[0])
            begin
                right_next = sat_add(s2_right_reg, val);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rd_ok_reg   <= q_entry.rd_ok;
            s1_playing_reg <= q_entry.playing;
            s1_left_reg    <= q_entry.left;
            s1_right_reg   <= q_entry.right;
            s2_playing_reg <= s1_playing_reg;
            s2_left_reg    <= s1_left_reg;
            s2_right_reg   <= s1_right_reg;
            product_reg    <= product_next;
            s3_playing_reg <= s2_playing_reg;
            s3_left_reg    <= left_next;
            s3_right_reg   <= right_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign left_out  = s3_left_reg;
    assign right_out = s3_right_reg;
    assign playing   = s3_playing_reg;

endmodule

>>> rtl/core/pcm_rhythm_sample_player.sv
// One-shot PCM drum sample player with a fractional play position.
// Input channel (in_valid / in_stall) carries one command per transaction:
// write a sample word, key-on (restart at position zero) or tick one frame.
// Every input transaction yields exactly one output transaction
// (out_valid / out_stall) carrying left_out, right_out and playing; a tick
// that is still within the sample and not muted adds the scaled sample into
// the incoming accumulators selected by pan with saturation, everything else
// passes them through. Throughput is one transaction per cycle while the
// output is not stalled. The front keeps the play position and classifies
// each command in the cycle it is taken; a two-entry queue feeds the back,
// which reads the sample store, multiplies by the volume and does the
// saturating adds in three registered steps. When the receiver stalls, the
// back holds still and the queue fills; the input stalls only once the
// queue is full. Configuration (cfg_we, cfg_index, cfg_data) must be written
// by the user while the block is idle; the block itself does not enforce
// this. Reset sets the position to idle and the registers to their defaults;
// the store is not cleared and an entry must be written before it is played.
module pcm_rhythm_sample_player #(
    parameter int SAMPLE_DEPTH = pcm_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pcm_pkg::CMD_W-1:0]            command,
    input  logic [pcm_pkg::SADDR_W-1:0]          sample_addr,
    input  logic signed [pcm_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic signed [pcm_pkg::ACC_W-1:0]     left_in,
    input  logic signed [pcm_pkg::ACC_W-1:0]     right_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pcm_pkg::ACC_W-1:0]     left_out,
    output logic signed [pcm_pkg::ACC_W-1:0]     right_out,
    output logic                                 playing
);
    import pcm_pkg::*;

    cfg_t   cfg_reg;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    entry_t push_entry;
    entry_t q_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step         <= STEP_RESET;
            cfg_reg.sample_count <= COUNT_RESET;
            cfg_reg.volume       <= VOLUME_RESET;
            cfg_reg.pan          <= PAN_RESET;
            cfg_reg.mute         <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP:   cfg_reg.step         <= cfg_data[STEP_W-1:0];
                REG_COUNT:  cfg_reg.sample_count <= cfg_data[COUNT_W-1:0];
                REG_VOLUME: cfg_reg.volume       <= cfg_data[VOL_W-1:0];
                REG_PAN:    cfg_reg.pan          <= cfg_data[PAN_W-1:0];
                REG_MUTE:   cfg_reg.mute         <= cfg_data[0];
                default:    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign in_stall = q_full;

    pcm_front #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .q_full       (q_full),
        .command      (command),
        .sample_addr  (sample_addr),
        .sample_value (sample_value),
        .left_in      (left_in),
        .right_in     (right_in),
        .push         (push),
        .entry        (push_entry)
    );

    pcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    pcm_back #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out),
        .playing   (playing)
    );

endmodule
